### sv/gtm_pkg.sv
// gtm_pkg: types, codes and constants for the gamepad to mouse mapper
// no dependencies; imported by gtm_front, gtm_back and the top level
package gtm_pkg;

    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_DEADZONE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPEED     = 3'd1;
    localparam logic [IDX_W-1:0] REG_WHEEL     = 3'd2;
    localparam logic [IDX_W-1:0] REG_POLL      = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLD      = 3'd4;
    localparam logic [IDX_W-1:0] REG_CHORD     = 3'd5;
    localparam logic [IDX_W-1:0] REG_HOTKEY    = 3'd6;

    localparam logic [2:0] KIND_MOTION = 3'd0;
    localparam logic [2:0] KIND_WHEEL  = 3'd1;
    localparam logic [2:0] KIND_BUTTON = 3'd2;
    localparam logic [2:0] KIND_HOTKEY = 3'd3;
    localparam logic [2:0] KIND_MODE   = 3'd4;

    // speed multipliers in q2.16: normal, slow (lb held), fast (rb held)
    localparam logic [17:0] MULT_ONE  = 18'd65536;
    localparam logic [17:0] MULT_SLOW = 18'd22938;
    localparam logic [17:0] MULT_FAST = 18'd131072;
    localparam logic [9:0]  POLL_MIN  = 10'd10;
    localparam logic [9:0]  POLL_MAX  = 10'd1000;
    localparam logic [14:0] AXIS_FULL = 15'd32767;

    typedef struct packed {
        logic [7:0]         button_bits;
        logic signed [15:0] axis_lx;
        logic signed [15:0] axis_ly;
        logic signed [15:0] axis_ry;
    } t_in;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [15:0] wheel_delta;
        logic [1:0]         button_id;
        logic               button_level;
        logic               mode_on;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [14:0] deadzone;
        logic [15:0] speed;
        logic [15:0] wheel_rate_q8;
        logic [9:0]  poll_rate;
        logic [15:0] hold_ticks;
        logic [3:0]  chord_mask;
        logic        hotkey_enable;
    } t_cfg;

    // work handed from the front part to the back part
    typedef struct packed {
        logic        hotkey;
        logic        flip;
        logic        mode_after;
        logic        mouse;
        logic        lb;
        logic        rb;
        logic [2:0]  btn_now;
        logic [2:0]  btn_prev;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] aw;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HEAD, ST_NORM, ST_MUL1, ST_MUL2, ST_DIV, ST_ACC,
        ST_EMIT
    } t_state;

endpackage

### sv/gtm_div.sv
// gtm_div: restoring serial divider, one quotient bit per cycle
// depends on nothing but its parameters
module gtm_div #(
    parameter int unsigned NW = 64,
    parameter int unsigned DW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;

    always_comb begin
        w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
    assign o_quo = r_q;
endmodule

### sv/gtm_front.sv
// gtm_front: accepts poll ticks, runs the chord and mode logic, queues jobs
// depends on gtm_pkg
module gtm_front
    import gtm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_data,
    output logic  o_job_valid,
    input  logic  i_job_take,
    output t_job  o_job
);
    // two-entry queue
    t_job       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic [7:0] r_prev;
    logic       r_mouse, r_timing, r_used;
    logic [15:0] r_count;

    logic w_acc;
    t_job w_job;
    logic n_mouse, n_timing, n_used;
    logic [15:0] n_count;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_acc       = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    always_comb begin
        logic [7:0] b;
        logic lb, rb, st, bk, mods, chord;
        b = i_data.button_bits;
        lb = b[4]; rb = b[5]; bk = b[6]; st = b[7];
        mods = lb && rb;
        n_mouse = r_mouse; n_timing = r_timing; n_used = r_used; n_count = r_count;
        w_job = '0;
        if (i_cfg.hotkey_enable && mods && st && !r_prev[7]) begin
            w_job.hotkey = 1'b1;
            n_timing = 1'b0;
            n_used = 1'b1;
        end
        chord = !((i_cfg.chord_mask[0] && !st) || (i_cfg.chord_mask[1] && !lb) ||
                  (i_cfg.chord_mask[2] && !rb) || (i_cfg.chord_mask[3] && !bk));
        w_job.btn_prev = r_prev[2:0];
        if (chord) begin
            if (mods) begin
                n_timing = 1'b0;
            end else if (!n_timing) begin
                n_timing = 1'b1;
                n_count = '0;
                n_used = 1'b0;
            end else begin
                if (r_count != 16'hFFFF) n_count = r_count + 1'b1;
                if (!n_used && n_count >= i_cfg.hold_ticks) begin
                    n_mouse = !r_mouse;
                    n_used = 1'b1;
                    w_job.flip = 1'b1;
                    w_job.btn_prev = b[2:0];
                end
            end
        end else begin
            n_timing = 1'b0;
            n_used = 1'b0;
        end
        w_job.mode_after = n_mouse;
        w_job.mouse = n_mouse;
        w_job.lb = lb;
        w_job.rb = rb;
        w_job.btn_now = b[2:0];
        w_job.ax = i_data.axis_lx;
        w_job.ay = i_data.axis_ly;
        w_job.aw = i_data.axis_ry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_prev <= '0; r_mouse <= 1'b0;
            r_timing <= 1'b0; r_used <= 1'b0; r_count <= '0;
        end else begin
            if (w_acc) begin
                r_prev <= i_data.button_bits;
                r_mouse <= n_mouse; r_timing <= n_timing;
                r_used <= n_used; r_count <= n_count;
            end
            if (o_job_valid && i_job_take) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, o_job_valid && i_job_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_q[r_rd ^ (r_cnt[0] ^ (o_job_valid && i_job_take))
                       ^ (o_job_valid && i_job_take)] <= w_job;
    end
endmodule

### sv/gtm_back.sv
// gtm_back: normalizes axes, scales them, runs the accumulators and emits beats
// depends on gtm_pkg and gtm_div
module gtm_back
    import gtm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_job_valid,
    output logic  o_job_take,
    input  t_job  i_job,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);
    localparam int unsigned NW = 64;
    localparam int unsigned DW = 42;

    t_state r_st, n_st;
    t_job   r_job;
    logic [1:0] r_ax;            // axis under work: 0 x, 1 y, 2 wheel
    logic [16:0] r_mag;
    logic        r_neg;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [32:0]  r_p1;
    logic signed [31:0] r_acc [3];
    logic signed [31:0] r_whole [3];
    // pending beats: 0 hotkey,1 mode,2-4 release,5 motion,6 wheel,7-9 buttons
    logic [9:0] r_pend;
    logic       r_div_go;
    logic       w_done;
    logic [NW-1:0] w_quo;

    gtm_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quo(w_quo)
    );

    logic [9:0]  w_poll;
    logic [17:0] w_mult;
    logic signed [15:0] w_axis;
    logic [16:0] w_av;
    logic [15:0] w_span;
    logic [31:0] w_mnum;
    logic [16:0] w_m;
    logic        w_zero;
    logic [50:0] w_prod;

    assign w_poll = (i_cfg.poll_rate < POLL_MIN) ? POLL_MIN :
                    (i_cfg.poll_rate > POLL_MAX) ? POLL_MAX : i_cfg.poll_rate;
    assign w_mult = r_job.lb ? MULT_SLOW : (r_job.rb ? MULT_FAST : MULT_ONE);
    assign w_axis = (r_ax == 2'd0) ? r_job.ax : (r_ax == 2'd1) ? r_job.ay : r_job.aw;
    assign w_av   = w_axis[15] ? 17'(17'h10000 - {1'b0, w_axis}) : {1'b0, w_axis};
    assign w_span = {1'b0, AXIS_FULL} - {1'b0, i_cfg.deadzone};
    assign w_mnum = 32'(w_av - {2'b0, i_cfg.deadzone}) << 15;
    assign w_m    = (w_quo > 64'd32768) ? 17'd32768 : w_quo[16:0];
    // magnitude at/below deadzone or full deadzone gives zero
    assign w_zero = (w_av <= {2'b0, i_cfg.deadzone}) || (i_cfg.deadzone == AXIS_FULL);
    assign w_prod = 51'(r_p1) * 51'(w_mult);

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [15:0] f_sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) return 16'sh7FFF;
        if (v < -32'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    logic [3:0] w_next;
    logic [9:0] w_rest;
    always_comb begin
        w_next = 4'd0;
        for (int k = 9; k >= 0; k--) if (r_pend[k]) w_next = 4'(k);
        w_rest = r_pend & ~(10'd1 << w_next);
    end

    // division phase flag: 0 normalize, 1 scale
    logic r_phase;
    logic signed [33:0] w_sum;
    logic [NW-1:0] w_step;
    logic signed [31:0] w_new, w_mag32, w_wh;

    always_comb begin
        w_step = w_quo;
        w_sum  = 34'(r_acc[r_ax]) + ((r_neg ^ (r_ax == 2'd2)) ? -34'(w_step[31:0])
                                                              : 34'(w_step[31:0]));
        w_new  = f_sat32(w_sum);
        w_mag32 = w_new[31] ? -w_new : w_new;
        w_wh   = 32'(w_mag32[31:FRAC_BITS]);
        if (w_new[31]) w_wh = -w_wh;
    end

    // next beat to send, lowest pending code first
    logic w_issue;
    t_out w_beat;
    assign w_issue = (r_st == ST_EMIT) && (!o_valid || !i_stall) && (r_pend != '0);

    always_comb begin
        w_beat = '0;
        w_beat.last = (w_rest == '0);
        unique case (w_next)
            4'd0: w_beat.kind = KIND_HOTKEY;
            4'd1: begin
                w_beat.kind = KIND_MODE;
                w_beat.mode_on = r_job.mode_after;
            end
            4'd2, 4'd3, 4'd4: begin
                w_beat.kind = KIND_BUTTON;
                w_beat.button_id = 2'(w_next - 4'd2);
            end
            4'd5: begin
                w_beat.kind = KIND_MOTION;
                w_beat.move_x = f_sat16(r_whole[0]);
                w_beat.move_y = f_sat16(r_whole[1]);
            end
            4'd6: begin
                w_beat.kind = KIND_WHEEL;
                w_beat.wheel_delta = f_sat16(r_whole[2]);
            end
            default: begin
                w_beat.kind = KIND_BUTTON;
                w_beat.button_id = 2'(w_next - 4'd7);
                w_beat.button_level = r_job.btn_now[2'(w_next - 4'd7)];
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        o_job_take = 1'b0;
        unique case (r_st)
            ST_IDLE: if (i_job_valid) begin o_job_take = 1'b1; n_st = ST_HEAD; end
            ST_HEAD: n_st = r_job.mouse ? ST_NORM : ST_EMIT;
            ST_NORM: n_st = ST_MUL1;
            ST_MUL1: n_st = ST_MUL2;
            ST_MUL2: n_st = ST_DIV;
            ST_DIV:  if (w_done) n_st = ST_ACC;
            ST_ACC:  n_st = (!r_phase) ? ST_MUL1 : ((r_ax == 2'd2) ? ST_EMIT : ST_NORM);
            ST_EMIT: if (r_pend == '0) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            o_valid <= 1'b0;
            r_pend <= '0;
            r_div_go <= 1'b0;
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
        end else begin
            r_div_go <= (r_st == ST_MUL2);
            if (w_issue) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: if (i_job_valid) r_job <= i_job;
                ST_HEAD: begin
                    r_ax <= 2'd0; r_phase <= 1'b0;
                    r_pend <= {5'b00000, {3{r_job.flip && !r_job.mode_after}},
                               r_job.flip, r_job.hotkey};
                    if (r_job.flip) for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                end
                ST_NORM: r_phase <= 1'b0;
                ST_MUL1: begin
                    if (!r_phase) begin
                        r_neg <= w_axis[15];
                        r_mag <= '0;
                        r_num <= w_zero ? '0 : NW'(w_mnum);
                        r_den <= (i_cfg.deadzone == AXIS_FULL) ? DW'(1) : DW'(w_span);
                    end else begin
                        r_p1 <= 33'(r_mag) * ((r_ax == 2'd2) ? 33'(i_cfg.wheel_rate_q8)
                                                             : 33'(i_cfg.speed));
                    end
                end
                ST_MUL2: begin
                    if (r_phase) begin
                        if (r_ax == 2'd2) begin
                            r_num <= NW'(r_p1) << FRAC_BITS;
                            r_den <= DW'(w_poll) << 23;
                        end else begin
                            r_num <= NW'(w_prod);
                            r_den <= DW'(w_poll) << (31 - FRAC_BITS);
                        end
                    end
                end
                ST_DIV: ;
                ST_ACC: begin
                    if (!r_phase) begin
                        r_mag <= w_m; r_phase <= 1'b1;
                    end else begin
                        r_acc[r_ax] <= w_new - (w_wh <<< FRAC_BITS);
                        r_whole[r_ax] <= w_wh;
                        r_ax <= r_ax + 1'b1;
                        if (r_ax == 2'd2)
                            r_pend <= {r_job.btn_now ^ r_job.btn_prev, w_wh != 0,
                                       (r_whole[0] != 0) || (r_whole[1] != 0), r_pend[4:0]};
                    end
                end
                ST_EMIT: if (w_issue) begin
                    r_pend <= w_rest;
                    o_data <= w_beat;
                end
                default: ;
            endcase
        end
    end

    // a beat only starts from the emit state
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_st) == ST_EMIT) else $error("beat outside emit");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> r_st == ST_IDLE) else $error("job taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("beat dropped");
endmodule

### sv/gamepad_to_mouse_mapper.sv
// gamepad_to_mouse_mapper: top level of the gamepad to mouse mapper
// depends on gtm_pkg, gtm_front, gtm_back (and gtm_div inside it)
//
// usage
// - input channel: one beat per poll tick (buttons and three stick axes),
//   taken when i_valid is high and o_stall is low
// - output channel: zero to six result beats per tick, the final one with
//   last set, taken when o_valid is high and i_stall is low
// - config port: write i_cfg_we with index and data while the block is idle
// - the front part keeps chord and mode state and queues up to two ticks,
//   so the input side keeps flowing while the back part works
// - work per tick: a tick in mouse mode runs six serial divisions (normalize
//   and scale for each of three axes) before its first result beat
// - a tick outside mouse mode skips the divisions and goes straight to
//   emitting its result beats
// - reset clears the control state and loads the default register values
// - a stalled output holds its beat; the back part waits, the queue fills,
//   then o_stall rises
module gamepad_to_mouse_mapper
    import gtm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    t_cfg r_cfg;
    logic w_jv, w_take;
    t_job w_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{deadzone: 15'd8000, speed: 16'd300, wheel_rate_q8: 16'd1152,
                       poll_rate: 10'd125, hold_ticks: 16'd500, chord_mask: 4'd3,
                       hotkey_enable: 1'b1};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEADZONE: r_cfg.deadzone      <= i_cfg_data[14:0];
                REG_SPEED:    r_cfg.speed         <= i_cfg_data;
                REG_WHEEL:    r_cfg.wheel_rate_q8 <= i_cfg_data;
                REG_POLL:     r_cfg.poll_rate     <= i_cfg_data[9:0];
                REG_HOLD:     r_cfg.hold_ticks    <= i_cfg_data;
                REG_CHORD:    r_cfg.chord_mask    <= i_cfg_data[3:0];
                REG_HOTKEY:   r_cfg.hotkey_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gtm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_job_valid(w_jv), .i_job_take(w_take), .o_job(w_job)
    );

    gtm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_job_valid(w_jv), .o_job_take(w_take), .i_job(w_job),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
